// File: rtl/isml_pkg.sv
// shared types and constants for the interval set merge and lookup block
package isml_pkg;

   localparam int MAX_INTERVALS_DEF = 16;
   localparam int TIME_WIDTH_DEF    = 32;

   typedef enum logic [1:0] {
      FN_INSERT = 2'd0,
      FN_LOOKUP = 2'd1,
      FN_CLEAR  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_EV,
      S_CHECK,
      S_COPY_RD,
      S_COPY_EV,
      S_LOOK_RD,
      S_LOOK_EV,
      S_DONE
   } state_type;

endpackage

// File: rtl/interval_set_merge_lookup.sv
// steps per item: clear, an empty insert and an unused code go straight to the result;
// a lookup reads the stored entries in order until the first hit or the last entry;
// an insert scans every stored entry, then a copy pass writes the kept entries and the new
// interval in order into the other bank; a full-table reject stops after the scan.
// one item at a time; a result held back by rsp_ready stalls the block in S_DONE.
// reset (synchronous) empties the table and drops any pending result; memory not cleared.
module interval_set_merge_lookup
   import isml_pkg::*;
#(
   parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
   parameter int TIME_WIDTH    = TIME_WIDTH_DEF,
   localparam int CNT_W        = $clog2(MAX_INTERVALS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   input  logic [TIME_WIDTH-1:0] req_start_time,
   input  logic [TIME_WIDTH-1:0] req_end_time,
   input  logic [TIME_WIDTH-1:0] req_query_time,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic                  rsp_hit,
   output logic [TIME_WIDTH-1:0] rsp_found_start,
   output logic [TIME_WIDTH-1:0] rsp_found_end,
   output logic [CNT_W-1:0]      rsp_entry_count
);

   localparam int IDX_W     = $clog2(MAX_INTERVALS);
   localparam int ADDR_W    = IDX_W + 1;
   localparam int MEM_DEPTH = 2 ** ADDR_W;

   // two banks: the copy pass reads one and writes the other
   logic [TIME_WIDTH-1:0] mem_start [MEM_DEPTH];
   logic [TIME_WIDTH-1:0] mem_end   [MEM_DEPTH];

   state_type             state_ff, state_in;
   logic                  bank_ff, bank_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]      wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0]      kept_cnt_ff, kept_cnt_in;
   logic [MAX_INTERVALS-1:0] kept_ff, kept_in;
   logic                  inserted_ff, inserted_in;
   logic [TIME_WIDTH-1:0] lo_ff, lo_in;
   logic [TIME_WIDTH-1:0] hi_ff, hi_in;
   logic [TIME_WIDTH-1:0] q_ff, q_in;
   status_type            status_ff, status_in;
   logic                  hit_ff, hit_in;
   logic [TIME_WIDTH-1:0] fs_ff, fs_in;
   logic [TIME_WIDTH-1:0] fe_ff, fe_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [TIME_WIDTH-1:0] rsp_fs_ff, rsp_fs_in;
   logic [TIME_WIDTH-1:0] rsp_fe_ff, rsp_fe_in;
   logic [CNT_W-1:0]      rsp_cnt_ff, rsp_cnt_in;

   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [TIME_WIDTH-1:0] rd_start_ff, rd_end_ff;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [TIME_WIDTH-1:0] wr_start, wr_end;

   logic                  accept;
   logic                  out_free;
   logic [CNT_W-1:0]      rd_next;
   logic                  rd_last;
   logic                  disjoint;

   assign req_ready       = (state_ff == S_IDLE);
   assign accept          = req_valid && req_ready;
   assign out_free        = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_found_start = rsp_fs_ff;
   assign rsp_found_end   = rsp_fe_ff;
   assign rsp_entry_count = rsp_cnt_ff;

   assign rd_addr  = {bank_ff, rd_idx_ff[IDX_W-1:0]};
   assign rd_next  = rd_idx_ff + CNT_W'(1);
   assign rd_last  = (rd_next == count_ff);
   assign disjoint = (rd_end_ff < lo_ff) || (rd_start_ff > hi_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_start[wr_addr] <= wr_start;
         mem_end[wr_addr]   <= wr_end;
      end
      if (rd_en) begin
         rd_start_ff <= mem_start[rd_addr];
         rd_end_ff   <= mem_end[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bank_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      wr_idx_ff     <= wr_idx_in;
      kept_cnt_ff   <= kept_cnt_in;
      kept_ff       <= kept_in;
      inserted_ff   <= inserted_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      q_ff          <= q_in;
      status_ff     <= status_in;
      hit_ff        <= hit_in;
      fs_ff         <= fs_in;
      fe_ff         <= fe_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_fs_ff     <= rsp_fs_in;
      rsp_fe_ff     <= rsp_fe_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   always_comb begin
      state_in      = state_ff;
      bank_in       = bank_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      wr_idx_in     = wr_idx_ff;
      kept_cnt_in   = kept_cnt_ff;
      kept_in       = kept_ff;
      inserted_in   = inserted_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      q_in          = q_ff;
      status_in     = status_ff;
      hit_in        = hit_ff;
      fs_in         = fs_ff;
      fe_in         = fe_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_fs_in     = rsp_fs_ff;
      rsp_fe_in     = rsp_fe_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = {~bank_ff, wr_idx_ff[IDX_W-1:0]};
      wr_start      = lo_ff;
      wr_end        = hi_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = ST_DONE;
               hit_in    = 1'b0;
               fs_in     = '0;
               fe_in     = '0;
               rd_idx_in = '0;
               state_in  = S_DONE;
               unique case (req_func)
                  FN_INSERT: begin
                     lo_in       = req_start_time;
                     hi_in       = req_end_time;
                     kept_cnt_in = '0;
                     if (req_end_time <= req_start_time) begin
                        status_in = ST_EMPTY;
                     end else if (count_ff == '0) begin
                        state_in = S_CHECK;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  FN_LOOKUP: begin
                     q_in = req_query_time;
                     if (count_ff != '0) begin
                        state_in = S_LOOK_RD;
                     end
                  end
                  FN_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SCAN_RD: begin
            rd_en    = 1'b1;
            state_in = S_SCAN_EV;
         end

         // fold an overlapping or touching entry into the new interval
         S_SCAN_EV: begin
            kept_in[rd_idx_ff[IDX_W-1:0]] = disjoint;
            if (disjoint) begin
               kept_cnt_in = kept_cnt_ff + CNT_W'(1);
            end else begin
               if (rd_start_ff < lo_ff) lo_in = rd_start_ff;
               if (rd_end_ff > hi_ff)   hi_in = rd_end_ff;
            end
            rd_idx_in = rd_next;
            state_in  = rd_last ? S_CHECK : S_SCAN_RD;
         end

         S_CHECK: begin
            rd_idx_in   = '0;
            wr_idx_in   = '0;
            inserted_in = 1'b0;
            if (kept_cnt_ff == CNT_W'(MAX_INTERVALS)) begin
               status_in = ST_FULL;
               state_in  = S_DONE;
            end else begin
               state_in = S_COPY_RD;
            end
         end

         S_COPY_RD: begin
            if (rd_idx_ff == count_ff) begin
               // end of the old table: append the new interval if still due
               if (!inserted_ff) begin
                  wr_en    = 1'b1;
                  count_in = wr_idx_ff + CNT_W'(1);
               end else begin
                  count_in = wr_idx_ff;
               end
               bank_in  = ~bank_ff;
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = S_COPY_EV;
            end
         end

         S_COPY_EV: begin
            priority if (!kept_ff[rd_idx_ff[IDX_W-1:0]]) begin
               rd_idx_in = rd_next;
               state_in  = S_COPY_RD;
            end else if (!inserted_ff && (rd_start_ff >= lo_ff)) begin
               // new interval goes ahead of this entry, which is taken next cycle
               wr_en       = 1'b1;
               wr_idx_in   = wr_idx_ff + CNT_W'(1);
               inserted_in = 1'b1;
            end else begin
               wr_en     = 1'b1;
               wr_start  = rd_start_ff;
               wr_end    = rd_end_ff;
               wr_idx_in = wr_idx_ff + CNT_W'(1);
               rd_idx_in = rd_next;
               state_in  = S_COPY_RD;
            end
         end

         S_LOOK_RD: begin
            rd_en    = 1'b1;
            state_in = S_LOOK_EV;
         end

         S_LOOK_EV: begin
            if ((q_ff >= rd_start_ff) && (q_ff <= rd_end_ff)) begin
               hit_in   = 1'b1;
               fs_in    = rd_start_ff;
               fe_in    = rd_end_ff;
               state_in = S_DONE;
            end else begin
               rd_idx_in = rd_next;
               state_in  = rd_last ? S_DONE : S_LOOK_RD;
            end
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_hit_in    = hit_ff;
               rsp_fs_in     = fs_ff;
               rsp_fe_in     = fe_ff;
               rsp_cnt_in    = count_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
